// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PRE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PRE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pre_pkg.sv =====
// Shared register index type, constants and helper function of the peak rate estimator.
package pre_pkg;

  localparam int MAX_LEN_DEF     = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SR_W     = 12;
  localparam int TH_W     = 16;
  localparam int CFG_W    = 16;
  localparam int PEAK_W   = 9;
  localparam int RATE_W   = 25;
  localparam int REFR_W   = 11;
  localparam int FIFO_DEPTH = 2;

  // The rate scale 60 * 256 is split into 15 times a shift by 10.
  localparam int SCALE_SHIFT = 10;
  localparam int PROD_W      = PEAK_W + SR_W;
  localparam int NUM_W       = PROD_W + 4 + SCALE_SHIFT;

  localparam int RECIP5       = 6554;
  localparam int RECIP5_SHIFT = 15;

  localparam logic [SR_W-1:0]        SAMPLE_RATE_RST = SR_W'(250);
  localparam logic signed [TH_W-1:0] THRESHOLD_RST   = TH_W'(819);
  localparam logic [PEAK_W-1:0]      PEAK_MAX        = '1;

  typedef enum logic [0:0] {
    REG_SAMPLE_RATE    = 1'b0,
    REG_PEAK_THRESHOLD = 1'b1
  } reg_idx_t;

  // Refractory length floor(2 * rate / 5), as a multiply by a reciprocal.
  function automatic logic [REFR_W-1:0] refractory_len(input logic [SR_W-1:0] rate);
    logic [SR_W:0]    dbl;
    logic [SR_W+16:0] prod;
    dbl  = {rate, 1'b0};
    prod = (SR_W+17)'(dbl) * (SR_W+17)'(RECIP5);
    return prod[RECIP5_SHIFT +: REFR_W];
  endfunction

endpackage

// ===== rtl/pre_front.sv =====
// Front part: per-sample peak test, record counters and record hand-off.
module pre_front import pre_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LEN_W       = $clog2(MAX_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          last,
  input  logic [SR_W-1:0]               sample_rate_hz,
  input  logic signed [TH_W-1:0]        peak_threshold,
  output logic                          rec_push,
  output logic [PEAK_W+LEN_W:0]         rec_data
);

  localparam int CMP_W = (SAMPLE_BITS > TH_W) ? SAMPLE_BITS : TH_W;

  logic signed [SAMPLE_BITS-1:0] older_sample, older_sample_next;
  logic signed [SAMPLE_BITS-1:0] newer_sample, newer_sample_next;
  logic [REFR_W-1:0]             refractory_left, refractory_left_next;
  logic [PEAK_W-1:0]             peak_counter, peak_counter_next;
  logic [LEN_W-1:0]              sample_counter, sample_counter_next;
  logic                          overflow_flag, overflow_flag_next;

  logic signed [CMP_W-1:0] x_e, old_e, new_e, th_e;
  logic                    is_peak;

  assign x_e   = CMP_W'(sample_value);
  assign old_e = CMP_W'(older_sample);
  assign new_e = CMP_W'(newer_sample);
  assign th_e  = CMP_W'(peak_threshold);
  assign is_peak = (new_e > old_e) && (new_e > x_e) && (new_e > th_e);

  always_comb begin
    older_sample_next    = older_sample;
    newer_sample_next    = newer_sample;
    refractory_left_next = refractory_left;
    peak_counter_next    = peak_counter;
    sample_counter_next  = sample_counter;
    overflow_flag_next   = overflow_flag;
    if (sample_counter < LEN_W'(MAX_LEN)) begin
      if (sample_counter >= LEN_W'(2)) begin
        if (refractory_left != '0) begin
          refractory_left_next = refractory_left - REFR_W'(1);
        end else if (is_peak) begin
          if (peak_counter != PEAK_MAX) begin
            peak_counter_next = peak_counter + PEAK_W'(1);
          end
          refractory_left_next = refractory_len(sample_rate_hz);
        end
      end
      older_sample_next   = newer_sample;
      newer_sample_next   = sample_value;
      sample_counter_next = sample_counter + LEN_W'(1);
    end else begin
      overflow_flag_next = 1'b1;
    end
  end

  assign rec_push = accept && last;
  assign rec_data = {peak_counter_next, sample_counter_next, overflow_flag_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample    <= '0;
      newer_sample    <= '0;
      refractory_left <= '0;
      peak_counter    <= '0;
      sample_counter  <= '0;
      overflow_flag   <= 1'b0;
    end else if (accept) begin
      if (last) begin
        older_sample    <= '0;
        newer_sample    <= '0;
        refractory_left <= '0;
        peak_counter    <= '0;
        sample_counter  <= '0;
        overflow_flag   <= 1'b0;
      end else begin
        older_sample    <= older_sample_next;
        newer_sample    <= newer_sample_next;
        refractory_left <= refractory_left_next;
        peak_counter    <= peak_counter_next;
        sample_counter  <= sample_counter_next;
        overflow_flag   <= overflow_flag_next;
      end
    end
  end

endmodule

// ===== rtl/pre_rec_fifo.sv =====
// Short queue of finished record summaries between the front and back parts.
module pre_rec_fifo import pre_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/pre_back.sv =====
// Back part: rate numerator, bit-serial division and the result register.
module pre_back import pre_pkg::*; #(
  parameter int LEN_W = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [PEAK_W+LEN_W:0] q_data,
  output logic                  q_pop,
  input  logic [SR_W-1:0]       sample_rate_hz,
  input  logic                  pop,
  output logic                  empty,
  output logic [RATE_W-1:0]     rate_bpm_q8,
  output logic [PEAK_W-1:0]     peak_total,
  output logic [LEN_W-1:0]      record_length,
  output logic                  overflowed
);

  localparam int DCNT_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t             state;
  logic [PEAK_W-1:0]  peaks;
  logic [LEN_W-1:0]   len;
  logic               ovf;
  logic [NUM_W-1:0]   dq;
  logic [LEN_W-1:0]   rem;
  logic [DCNT_W-1:0]  dcnt;
  logic               out_valid;

  logic [PROD_W-1:0]   prod;
  logic [PROD_W+3:0]   prod15;
  logic [NUM_W-1:0]    num;
  logic                rec_ok;
  logic [LEN_W:0]      rem_sh;
  logic                q_bit;
  logic                load;

  assign prod   = PROD_W'(peaks) * PROD_W'(sample_rate_hz);
  assign prod15 = {prod, 4'b0} - (PROD_W+4)'(prod);
  assign num    = {prod15, {SCALE_SHIFT{1'b0}}};
  assign rec_ok = (len >= LEN_W'(3)) && (sample_rate_hz != '0);

  assign rem_sh = {rem, dq[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, len});

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign load  = (state == S_LOAD) && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= rec_ok ? S_DIV : S_LOAD;
        end
        S_DIV: begin
          if (dcnt == '0) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {peaks, len, ovf} <= q_data;
    end
    if (state == S_MUL) begin
      dq   <= rec_ok ? num : '0;
      rem  <= '0;
      dcnt <= DCNT_W'(NUM_W - 1);
    end
    if (state == S_DIV) begin
      rem  <= q_bit ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
      dq   <= {dq[NUM_W-2:0], q_bit};
      dcnt <= dcnt - DCNT_W'(1);
    end
    if (load) begin
      rate_bpm_q8   <= dq[RATE_W-1:0];
      peak_total    <= peaks;
      record_length <= len;
      overflowed    <= ovf;
    end
  end

endmodule

// ===== rtl/peak_rate_estimator_core.sv =====
// Top level of the peak rate estimator: configuration registers and part wiring.
//
// Samples enter on the input queue port: a transfer happens when push is high
// and full is low. A sample with last high closes its record. Each record
// gives one result on the output queue port, shown while empty is low and
// taken when pop is high. Peak testing runs at one sample per cycle while
// full is low. A finished record summary waits in a two-entry queue. The
// back part takes it, forms the rate numerator and runs its one-bit-per-cycle
// divider over a 35-bit numerator, taking no new record until the result is
// loaded. A record shorter than three samples, or one taken at a zero sample
// rate, skips the divider. If records close faster than the back part takes
// them, the queue fills and full rises until it catches up. A result held
// by a stalled receiver stays on the output ports while the next record is
// divided behind it. Reset empties all queues, clears the record state and
// restores the sample rate to 250 Hz and the threshold to 819. The user
// writes configuration with cfg_write, cfg_index and cfg_data only while no
// record is in flight; the block itself does not enforce this.
module peak_rate_estimator_core import pre_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LEN_W       = $clog2(MAX_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          last,
  output logic                          empty,
  input  logic                          pop,
  output logic [RATE_W-1:0]             rate_bpm_q8,
  output logic [PEAK_W-1:0]             peak_total,
  output logic [LEN_W-1:0]              record_length,
  output logic                          overflowed,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  logic [SR_W-1:0]        sample_rate_hz;
  logic signed [TH_W-1:0] peak_threshold;
  logic                   accept;
  logic                   rec_push;
  logic [PEAK_W+LEN_W:0]  rec_data, q_data;
  logic                   q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz <= SAMPLE_RATE_RST;
      peak_threshold <= THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_RATE:    sample_rate_hz <= cfg_data[SR_W-1:0];
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_data[TH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  pre_front #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .LEN_W      (LEN_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample_value  (sample_value),
    .last          (last),
    .sample_rate_hz(sample_rate_hz),
    .peak_threshold(peak_threshold),
    .rec_push      (rec_push),
    .rec_data      (rec_data)
  );

  pre_rec_fifo #(
    .WIDTH(PEAK_W + LEN_W + 1),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wr_data(rec_data),
    .pop    (q_pop),
    .rd_data(q_data),
    .full   (full),
    .empty  (q_empty)
  );

  pre_back #(
    .LEN_W(LEN_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .sample_rate_hz(sample_rate_hz),
    .pop           (pop),
    .empty         (empty),
    .rate_bpm_q8   (rate_bpm_q8),
    .peak_total    (peak_total),
    .record_length (record_length),
    .overflowed    (overflowed)
  );

endmodule

// ===== rtl/pre_checker.sv =====
// Port-level checker of the peak rate estimator and its bind to the top level.
`include "assert_macros.svh"

module pre_checker import pre_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input logic [RATE_W-1:0] rate_bpm_q8,
  input logic [PEAK_W-1:0] peak_total,
  input logic [LEN_W-1:0]  record_length
);

  `PRE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result pending after reset")
  `PRE_ASSERT(a_hold_result, clk, rst, !empty && !pop |=> $stable(rate_bpm_q8), "result changed while stalled")
  `PRE_ASSERT(a_len_bound, clk, rst, !empty |-> record_length <= LEN_W'(MAX_LEN), "record length above maximum")
  `PRE_ASSERT(a_short_rate, clk, rst, !empty && record_length < LEN_W'(3) |-> rate_bpm_q8 == '0, "nonzero rate on short record")
  `PRE_ASSERT(a_peak_bound, clk, rst, !empty |-> (LEN_W+PEAK_W)'(peak_total) <= (LEN_W+PEAK_W)'(record_length), "more peaks than samples")

endmodule

bind peak_rate_estimator_core pre_checker #(
  .MAX_LEN(MAX_LEN),
  .LEN_W  (LEN_W)
) u_pre_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .rate_bpm_q8  (rate_bpm_q8),
  .peak_total   (peak_total),
  .record_length(record_length)
);
